/* rtl/qfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfq_pkg
// Shared types, constants and float helpers for the Q-format quantizer.
// ----------------------------------------------------------------------------
package qfq_pkg;

    localparam logic [31:0] FLT_MAX_BITS    = 32'h7F7F_FFFF;
    localparam logic [31:0] FLT_LOWEST_BITS = 32'hFF7F_FFFF;
    localparam logic [3:0]  Q_TOP           = 4'd15;
    localparam logic [15:0] SAT_HI          = 16'h7FFF;
    localparam logic [15:0] SAT_LO          = 16'h8000;
    localparam logic [7:0]  EXP_BIAS        = 8'd127;
    localparam logic [7:0]  EXP_SPECIAL     = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic search_init;
        logic search_step;
        logic rd_issue;
        logic out_load;
        logic idx_inc;
        logic clear;
    } qfq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fit;
        logic q_zero;
        logic count_zero;
        logic last_idx;
    } qfq_sts_t;

    function automatic logic flt_is_nan(input logic [31:0] a);
        return (a[30:23] == EXP_SPECIAL) && (a[22:0] != 23'd0);
    endfunction

    // IEEE less-than on bit patterns: false on NaN, and -0 equals +0.
    function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
        logic res;
        if (flt_is_nan(a) || flt_is_nan(b))
            res = 1'b0;
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            res = 1'b0;
        else if (a[31] != b[31])
            res = a[31];
        else if (!a[31])
            res = a[30:0] < b[30:0];
        else
            res = a[30:0] > b[30:0];
        return res;
    endfunction

    // Lower bound -32768 * 2^-q as a float.
    function automatic logic [31:0] q_rmin(input logic [3:0] q);
        logic [7:0] ex;
        ex = EXP_BIAS + 8'd15 - {4'd0, q};
        return {1'b1, ex, 23'd0};
    endfunction

    // Upper bound 32767 * 2^-q as a float.
    function automatic logic [31:0] q_rmax(input logic [3:0] q);
        logic [7:0] ex;
        ex = EXP_BIAS + 8'd14 - {4'd0, q};
        return {1'b0, ex, 23'h7F_FE00};
    endfunction

    // value * 2^q, truncated toward zero, saturated to int16, NaN to zero.
    function automatic logic [15:0] flt_to_q16(input logic [31:0] v, input logic [3:0] q);
        logic signed [9:0] e;
        logic [4:0]  sh;
        logic [23:0] mag24;
        logic [15:0] mag;
        logic [15:0] res;
        e     = $signed({2'b00, v[30:23]}) - $signed({2'b00, EXP_BIAS})
                + $signed({6'd0, q});
        sh    = 5'(10'sd23 - e);
        mag24 = {1'b1, v[22:0]} >> sh;
        mag   = {1'b0, mag24[14:0]};
        if (v[30:23] == EXP_SPECIAL)
            res = (v[22:0] != 23'd0) ? 16'd0 : (v[31] ? SAT_LO : SAT_HI);
        else if (v[30:23] == 8'd0 || e < 10'sd0)
            res = 16'd0;
        else if (e >= 10'sd15)
            res = v[31] ? SAT_LO : SAT_HI;
        else
            res = v[31] ? (16'd0 - mag) : mag;
        return res;
    endfunction

endpackage

/* rtl/qfq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

/* rtl/qfq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfq_datapath
// Value store, running bounds, Q search and int16 conversion.
// ----------------------------------------------------------------------------
module qfq_datapath #(
    parameter int SET_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  qfq_pkg::qfq_cmd_t cmd,
    output qfq_pkg::qfq_sts_t sts,
    input  logic [31:0]      value,
    output logic [15:0]      quantized,
    output logic [3:0]       q_format,
    output logic             range_exceeded,
    output logic             last_out
);
    import qfq_pkg::*;

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic [31:0]   min_reg;
    logic [31:0]   max_reg;
    logic [3:0]    q_reg;
    logic          exc_reg;
    logic [15:0]   quant_reg;
    logic          last_reg;
    logic [31:0]   rdata;
    logic          full;
    logic          do_store;
    logic [CW-1:0] idx_ext;

    assign full     = (count_reg == CW'(SET_DEPTH));
    assign do_store = cmd.store && !full;
    assign idx_ext  = CW'(idx_reg);

    qfq_ram #(
        .WIDTH(32),
        .DEPTH(SET_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (do_store),
        .waddr(count_reg[AW-1:0]),
        .wdata(value),
        .re   (cmd.rd_issue),
        .raddr(idx_reg),
        .rdata(rdata)
    );

    // Status toward the controller.
    assign sts.fit        = !flt_lt(min_reg, q_rmin(q_reg)) && !flt_lt(q_rmax(q_reg), max_reg);
    assign sts.q_zero     = (q_reg == 4'd0);
    assign sts.count_zero = (count_reg == '0);
    assign sts.last_idx   = (idx_ext == count_reg - CW'(1));

    // Set bookkeeping: count, bounds, Q search and read index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= FLT_MAX_BITS;
            max_reg   <= FLT_LOWEST_BITS;
            q_reg     <= Q_TOP;
            exc_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                min_reg   <= FLT_MAX_BITS;
                max_reg   <= FLT_LOWEST_BITS;
            end
            else if (do_store)
            begin
                count_reg <= count_reg + CW'(1);
                if (flt_lt(value, min_reg))
                    min_reg <= value;
                if (flt_lt(max_reg, value))
                    max_reg <= value;
            end
            if (cmd.search_init)
            begin
                q_reg   <= Q_TOP;
                idx_reg <= '0;
            end
            else if (cmd.search_step)
            begin
                if (sts.fit)
                    exc_reg <= 1'b0;
                else if (sts.q_zero)
                    exc_reg <= 1'b1;
                else
                    q_reg <= q_reg - 4'd1;
            end
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + AW'(1);
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            quant_reg <= flt_to_q16(rdata, q_reg);
            last_reg  <= sts.last_idx;
        end
    end

    assign quantized      = quant_reg;
    assign q_format       = q_reg;
    assign range_exceeded = exc_reg;
    assign last_out       = last_reg;

endmodule

/* rtl/qfq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfq_ctrl
// Controller state machine: load, Q search and emission sequencing.
// ----------------------------------------------------------------------------
module qfq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output qfq_pkg::qfq_cmd_t cmd,
    input  qfq_pkg::qfq_sts_t sts
);
    import qfq_pkg::*;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CONV   = 3'd3;
    localparam logic [2:0] ST_SEND   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_SEND);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (last)
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.fit || sts.q_zero)
                begin
                    if (sts.count_zero)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    if (sts.last_idx)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output channels active together");
    a_clear_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (state_reg == ST_LOAD))
        else $error("set clear did not return to load");
    a_read_then_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_CONV))
        else $error("read not followed by conversion");
    a_search_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> (state_reg == ST_SEARCH))
        else $error("last request did not start Q search");
`endif

endmodule

/* rtl/int16_q_format_quantizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int16_q_format_quantizer
// Collects a set of float32 values, picks a common Q format and emits int16.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   value[31:0], last
// out      output     out_valid / out_ready quantized[15:0], q_format[3:0],
//                                           range_exceeded, last_out
//
// Loading takes one request per cycle. After the last request the Q search
// tries Q from 15 down to 0, one candidate Q per cycle in a single
// comparator pair. Each result then passes a store RAM read, a conversion
// into the output register, and the transfer, which output stalls hold.
// Input is not accepted while a set is being emitted; out stalls hold the
// current result. Reset empties the set; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module int16_q_format_quantizer #(
    parameter int SET_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] quantized,
    output logic [3:0]  q_format,
    output logic        range_exceeded,
    output logic        last_out
);
    import qfq_pkg::*;

    qfq_cmd_t cmd;
    qfq_sts_t sts;

    // Controller.
    qfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .last     (last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath.
    qfq_datapath #(
        .SET_DEPTH(SET_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .value         (value),
        .quantized     (quantized),
        .q_format      (q_format),
        .range_exceeded(range_exceeded),
        .last_out      (last_out)
    );

endmodule
